// ===== rtl/dpcb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpcb_pkg: shared types and constants of the debounced pulse counter bank
// Opcodes, result kinds, back-end states, the command queue entry and the
// result bundle that the front, the queue and the back end exchange.
// ----------------------------------------------------------------------------
package dpcb_pkg;

    localparam int DPCB_CHANNELS = 8;
    localparam int DPCB_Q_DEPTH  = 2;
    localparam int MS_PER_S      = 1000;
    localparam int DIV_STEPS     = 32;

    localparam logic [1:0] CFG_ENABLED    = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd1;
    localparam logic [1:0] CFG_INTERVAL   = 2'd2;
    localparam logic [1:0] CFG_SAVE_EVERY = 2'd3;

    localparam logic [7:0] ENABLED_RESET  = 8'hff;
    localparam logic [7:0] INTERVAL_RESET = 8'd60;

    typedef enum logic [1:0] {
        OP_PIN  = 2'd0,
        OP_TICK = 2'd1,
        OP_SET  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_EDGE     = 2'd0,
        KIND_PERIODIC = 2'd1,
        KIND_ECHO     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_MOD,
        ST_TICK,
        ST_REPORT,
        ST_SET
    } t_back_state;

    typedef struct packed {
        t_op         op;
        logic [2:0]  ch;
        logic [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [2:0]  ch;
        logic [31:0] count;
        logic        save;
        logic        last;
    } t_result;

endpackage

// ===== rtl/dpcb_front.sv =====
// ----------------------------------------------------------------------------
// dpcb_front: request intake and classification
// Drops requests that cannot produce any effect and turns the rest into
// queue commands.
// ----------------------------------------------------------------------------
module dpcb_front #(
    parameter int CHANNELS = dpcb_pkg::DPCB_CHANNELS
) (
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        i_opcode,
    input  logic [2:0]        i_channel,
    input  logic              i_level,
    input  logic [31:0]       i_new_count,
    input  logic [7:0]        i_enabled,
    output logic              o_push,
    output dpcb_pkg::t_cmd    o_cmd
);
    import dpcb_pkg::*;

    logic w_present;
    logic w_keep;
    t_op  w_op;

    assign w_present = (32'(i_channel) < CHANNELS) && i_enabled[i_channel];

    always_comb begin
        w_keep = 1'b0;
        w_op   = OP_TICK;
        case (i_opcode)
            OP_PIN: begin
                w_keep = w_present && !i_level;
                w_op   = OP_PIN;
            end
            OP_TICK: begin
                w_keep = 1'b1;
                w_op   = OP_TICK;
            end
            OP_SET: begin
                w_keep = w_present;
                w_op   = OP_SET;
            end
            default: begin
                w_keep = 1'b0;
                w_op   = OP_TICK;
            end
        endcase
    end

    assign o_push       = start && !busy && w_keep;
    assign o_cmd.op     = w_op;
    assign o_cmd.ch     = i_channel;
    assign o_cmd.value  = i_new_count;

endmodule

// ===== rtl/dpcb_queue.sv =====
// ----------------------------------------------------------------------------
// dpcb_queue: command queue between front and back end
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module dpcb_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dpcb_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output dpcb_pkg::t_cmd      o_head,
    output dpcb_pkg::t_q_status o_status
);
    import dpcb_pkg::*;

    localparam int PTR_W = (DPCB_Q_DEPTH > 1) ? $clog2(DPCB_Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(DPCB_Q_DEPTH + 1);

    t_cmd             r_mem [DPCB_Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DPCB_Q_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? f_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? f_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DPCB_Q_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== rtl/dpcb_back.sv =====
// ----------------------------------------------------------------------------
// dpcb_back: command execution
// Holds time, counts and last-edge times; runs debounce, a bit-serial
// remainder for save requests, and the periodic report sweep.
// ----------------------------------------------------------------------------
module dpcb_back #(
    parameter int CHANNELS = dpcb_pkg::DPCB_CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpcb_pkg::t_q_status i_q_status,
    input  dpcb_pkg::t_cmd      i_head,
    output logic                o_pop,
    input  logic [7:0]          i_enabled,
    input  logic [15:0]         i_debounce,
    input  logic [7:0]          i_interval,
    input  logic [15:0]         i_save_every,
    input  logic                i_interval_wr,
    output dpcb_pkg::t_result   o_result
);
    import dpcb_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STEP_W = $clog2(DIV_STEPS);

    t_back_state      r_state, n_state;
    logic [2:0]       r_ch, n_ch;
    logic [31:0]      r_value, n_value;
    logic [31:0]      r_now, n_now;
    logic [17:0]      r_elapsed, n_elapsed;
    logic [31:0]      r_sh, n_sh;
    logic [15:0]      r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    t_result          r_out, n_out;

    logic [31:0]      r_count [CHANNELS];
    logic [31:0]      r_last  [CHANNELS];

    logic             w_cnt_we;
    logic [31:0]      w_cnt_data;
    logic             w_last_we;

    logic [31:0]      w_cur_count;
    logic [31:0]      w_cur_last;
    logic [31:0]      w_diff;
    logic [31:0]      w_inc;
    logic [16:0]      w_trial;
    logic [15:0]      w_rem_next;
    logic [17:0]      w_elapsed_inc;
    logic [17:0]      w_limit;
    logic             w_above;

    assign w_cur_count = r_count[r_ch[CH_W-1:0]];
    assign w_cur_last  = r_last[r_ch[CH_W-1:0]];
    assign w_diff      = r_now - w_cur_last;
    assign w_inc       = w_cur_count + 32'd1;
    assign w_trial     = {r_rem, r_sh[31]};
    assign w_rem_next  = (w_trial >= {1'b0, i_save_every})
                         ? 16'(w_trial - {1'b0, i_save_every}) : w_trial[15:0];
    assign w_elapsed_inc = r_elapsed + 18'd1;
    assign w_limit       = 18'(i_interval) * 18'(MS_PER_S);

    // any enabled channel after the one being reported
    always_comb begin
        w_above = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if ((3'(i) > r_ch) && i_enabled[i]) begin
                w_above = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_value   = r_value;
        n_now     = r_now;
        n_elapsed = r_elapsed;
        n_sh      = r_sh;
        n_rem     = r_rem;
        n_step    = r_step;
        n_out     = r_out;
        n_out.valid = 1'b0;
        o_pop      = 1'b0;
        w_cnt_we   = 1'b0;
        w_cnt_data = w_inc;
        w_last_we  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_ch    = i_head.ch;
                    n_value = i_head.value;
                    case (i_head.op)
                        OP_PIN:  n_state = ST_EDGE;
                        OP_TICK: n_state = ST_TICK;
                        OP_SET:  n_state = ST_SET;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EDGE: begin
                if ((i_debounce != 16'd0) && (w_diff < {16'd0, i_debounce})) begin
                    // bounce: drop silently
                    n_state = ST_IDLE;
                end else begin
                    w_last_we  = (i_debounce != 16'd0);
                    w_cnt_we   = 1'b1;
                    w_cnt_data = w_inc;
                    n_value    = w_inc;
                    if (i_save_every != 16'd0) begin
                        n_sh    = w_inc;
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = ST_MOD;
                    end else begin
                        n_out.valid = 1'b1;
                        n_out.kind  = KIND_EDGE;
                        n_out.ch    = r_ch;
                        n_out.count = w_inc;
                        n_out.save  = 1'b0;
                        n_out.last  = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_MOD: begin
                n_rem  = w_rem_next;
                n_sh   = {r_sh[30:0], 1'b0};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_out.valid = 1'b1;
                    n_out.kind  = KIND_EDGE;
                    n_out.ch    = r_ch;
                    n_out.count = r_value;
                    n_out.save  = (w_rem_next == 16'd0);
                    n_out.last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_TICK: begin
                n_now   = r_now + 32'd1;
                n_state = ST_IDLE;
                if (i_interval == 8'd0) begin
                    n_elapsed = '0;
                end else if (w_elapsed_inc >= w_limit) begin
                    n_elapsed = '0;
                    n_ch      = '0;
                    n_state   = ST_REPORT;
                end else begin
                    n_elapsed = w_elapsed_inc;
                end
            end
            ST_REPORT: begin
                if (i_enabled[r_ch]) begin
                    n_out.valid = 1'b1;
                    n_out.kind  = KIND_PERIODIC;
                    n_out.ch    = r_ch;
                    n_out.count = w_cur_count;
                    n_out.save  = 1'b0;
                    n_out.last  = !w_above;
                end
                if (r_ch == 3'(CHANNELS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_ch = r_ch + 3'd1;
                end
            end
            ST_SET: begin
                w_cnt_we    = 1'b1;
                w_cnt_data  = r_value;
                n_out.valid = 1'b1;
                n_out.kind  = KIND_ECHO;
                n_out.ch    = r_ch;
                n_out.count = r_value;
                n_out.save  = 1'b0;
                n_out.last  = 1'b1;
                n_state     = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_interval_wr) begin
            n_elapsed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_elapsed   <= '0;
            r_out.valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_elapsed   <= n_elapsed;
            r_out.valid <= n_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch        <= n_ch;
        r_value     <= n_value;
        r_sh        <= n_sh;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_out.kind  <= n_out.kind;
        r_out.ch    <= n_out.ch;
        r_out.count <= n_out.count;
        r_out.save  <= n_out.save;
        r_out.last  <= n_out.last;
    end

    // per-channel state clears at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i] <= '0;
                r_last[i]  <= '0;
            end
        end else begin
            if (w_cnt_we) begin
                r_count[r_ch[CH_W-1:0]] <= w_cnt_data;
            end
            if (w_last_we) begin
                r_last[r_ch[CH_W-1:0]] <= r_now;
            end
        end
    end

    assign o_result = r_out;

endmodule

// ===== rtl/debounced_pulse_counter_bank_top.sv =====
// ----------------------------------------------------------------------------
// debounced_pulse_counter_bank_top: multichannel debounced pulse counter
// A request goes from the front into the queue; the back end pops it, runs
//   edge (with 32-step bit-serial save remainder), set or tick/sweep states
//   and registers the result; the queue takes new requests unless it is full.
// The receiver cannot stall: each result shows for one cycle on o_valid.
// Synchronous active-low reset clears time, counts, last-edge times, queue.
// ----------------------------------------------------------------------------
module debounced_pulse_counter_bank_top #(
    parameter int CHANNELS = dpcb_pkg::DPCB_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_channel,
    input  logic        i_level,
    input  logic [31:0] i_new_count,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // result channel
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_report_channel,
    output logic [31:0] o_count_value,
    output logic        o_save_request,
    output logic        o_last_of_run
);
    import dpcb_pkg::*;

    // configuration registers
    logic [7:0]  r_enabled;
    logic [15:0] r_debounce;
    logic [7:0]  r_interval;
    logic [15:0] r_save_every;
    logic        w_interval_wr;

    logic        w_push;
    logic        w_pop;
    t_cmd        w_cmd;
    t_cmd        w_head;
    t_q_status   w_q_status;
    t_result     w_result;

    // Writing the interval also restarts it, so tell the back end.
    assign w_interval_wr = i_cfg_we && (i_cfg_idx == CFG_INTERVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= ENABLED_RESET;
            r_debounce   <= '0;
            r_interval   <= INTERVAL_RESET;
            r_save_every <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLED:    r_enabled    <= i_cfg_data[7:0];
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                CFG_INTERVAL:   r_interval   <= i_cfg_data[7:0];
                CFG_SAVE_EVERY: r_save_every <= i_cfg_data;
                default:        r_enabled    <= r_enabled;
            endcase
        end
    end

    // Hold off new requests only when the queue has no room.
    assign busy = w_q_status.full;

    // Front: accept and classify; requests that cannot have an effect never enter the queue.
    dpcb_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_channel   (i_channel),
        .i_level     (i_level),
        .i_new_count (i_new_count),
        .i_enabled   (r_enabled),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    // Queue decouples intake from the multi-cycle back end.
    dpcb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // Back end: execute one command at a time and drive the result register.
    dpcb_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_enabled     (r_enabled),
        .i_debounce    (r_debounce),
        .i_interval    (r_interval),
        .i_save_every  (r_save_every),
        .i_interval_wr (w_interval_wr),
        .o_result      (w_result)
    );

    assign o_valid          = w_result.valid;
    assign o_kind           = w_result.kind;
    assign o_report_channel = w_result.ch;
    assign o_count_value    = w_result.count;
    assign o_save_request   = w_result.save;
    assign o_last_of_run    = w_result.last;

endmodule

// ===== rtl/dpcb_checker.sv =====
// ----------------------------------------------------------------------------
// dpcb_checker: port-level checks for the pulse counter bank
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module dpcb_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_kind,
    input logic [2:0]  o_report_channel,
    input logic        o_save_request,
    input logic        o_last_of_run
);
    import dpcb_pkg::*;

    // reset empties the queue and drops any pending result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("result or busy after reset");

    // edge reports and echoes are single-result runs
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_PERIODIC) |-> o_last_of_run)
        else $error("single result without last mark");

    // only edge reports can carry a save request
    a_save_edge_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_EDGE) |-> !o_save_request)
        else $error("save request on non-edge result");

    // a periodic sweep goes up in channel order
    a_sweep_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_PERIODIC) && $past(o_valid)
        && ($past(o_kind) == KIND_PERIODIC) && !$past(o_last_of_run)
        |-> o_report_channel > $past(o_report_channel))
        else $error("periodic sweep out of order");

endmodule

bind debounced_pulse_counter_bank_top dpcb_port_checks u_dpcb_port_checks (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_kind           (o_kind),
    .o_report_channel (o_report_channel),
    .o_save_request   (o_save_request),
    .o_last_of_run    (o_last_of_run)
);

// ===== sim/dpcb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpcb_checker: scoreboard for the debounced pulse counter bank
// Tracks register writes and accepted requests, keeps its own millisecond
// time, counts and edge stamps, and compares every strobed result with the
// oldest predicted report, field by field.
// ----------------------------------------------------------------------------
module dpcb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_channel,
    input  logic        i_level,
    input  logic [31:0] i_new_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_report_channel,
    input  logic [31:0] i_count_value,
    input  logic        i_save_request,
    input  logic        i_last_of_run,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    import dpcb_pkg::*;

    localparam int CH = DPCB_CHANNELS;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  ch;
        logic [31:0] count;
        logic        save;
        logic        last;
    } t_count_report;

    t_count_report expected_reports[$];
    t_count_report want_rpt;

    logic [7:0]  enabled_mask;
    logic [15:0] debounce_ms;
    logic [7:0]  interval_s;
    logic [15:0] save_every;

    logic [31:0] clock_ms;
    logic [31:0] edge_stamp [CH];
    logic [31:0] tally [CH];
    logic [17:0] since_report_ms;

    int errors  = 0;
    int checked = 0;

    task automatic queue_report(input t_kind kind, input logic [2:0] ch,
                                input logic [31:0] count, input logic save,
                                input logic last);
        t_count_report rpt;
        rpt.kind  = kind;
        rpt.ch    = ch;
        rpt.count = count;
        rpt.save  = save;
        rpt.last  = last;
        expected_reports.push_back(rpt);
    endtask

    task automatic predict_request(input logic [1:0] op, input logic [2:0] ch,
                                   input logic lvl, input logic [31:0] value);
        logic [31:0] since_edge;
        logic [31:0] period_ms;
        logic        save;
        int          top_ch;
        int          c;
        case (op)
            OP_PIN: begin
                if (enabled_mask[ch] && !lvl) begin
                    since_edge = clock_ms - edge_stamp[ch];
                    if (debounce_ms == 16'd0 || since_edge >= {16'd0, debounce_ms}) begin
                        // zero debounce leaves the edge stamp alone
                        if (debounce_ms != 16'd0)
                            edge_stamp[ch] = clock_ms;
                        tally[ch] = tally[ch] + 32'd1;
                        save = (save_every != 16'd0) &&
                               (tally[ch] % {16'd0, save_every} == 32'd0);
                        queue_report(KIND_EDGE, ch, tally[ch], save, 1'b1);
                    end
                end
            end
            OP_TICK: begin
                clock_ms = clock_ms + 32'd1;
                if (interval_s == 8'd0) begin
                    since_report_ms = '0;
                end else begin
                    since_report_ms = since_report_ms + 18'd1;
                    period_ms = interval_s * 32'(MS_PER_S);
                    if ({14'd0, since_report_ms} >= period_ms) begin
                        since_report_ms = '0;
                        top_ch = -1;
                        for (c = 0; c < CH; c++)
                            if (enabled_mask[c])
                                top_ch = c;
                        for (c = 0; c < CH; c++)
                            if (enabled_mask[c])
                                queue_report(KIND_PERIODIC, c[2:0], tally[c], 1'b0,
                                             c == top_ch);
                    end
                end
            end
            OP_SET: begin
                if (enabled_mask[ch]) begin
                    tally[ch] = value;
                    queue_report(KIND_ECHO, ch, value, 1'b0, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enabled_mask    = ENABLED_RESET;
            debounce_ms     = '0;
            interval_s      = INTERVAL_RESET;
            save_every      = '0;
            clock_ms        = '0;
            since_report_ms = '0;
            for (int c = 0; c < CH; c++) begin
                edge_stamp[c] = '0;
                tally[c]      = '0;
            end
            expected_reports.delete();
        end else begin
            if (i_valid) begin
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with nothing expected, %s %0d %0d %0d",
                             $time, "kind/channel/count", i_kind, i_report_channel,
                             i_count_value);
                end else begin
                    want_rpt = expected_reports.pop_front();
                    checked++;
                    flag_field("kind", 32'(want_rpt.kind), 32'(i_kind));
                    flag_field("report_channel", 32'(want_rpt.ch),
                               32'(i_report_channel));
                    flag_field("count_value", want_rpt.count, i_count_value);
                    flag_field("save_request", 32'(want_rpt.save),
                               32'(i_save_request));
                    flag_field("last_of_run", 32'(want_rpt.last),
                               32'(i_last_of_run));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLED:    enabled_mask = i_cfg_data[7:0];
                    CFG_DEBOUNCE:   debounce_ms  = i_cfg_data;
                    CFG_INTERVAL: begin
                        interval_s      = i_cfg_data[7:0];
                        since_report_ms = '0;
                    end
                    CFG_SAVE_EVERY: save_every   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                predict_request(i_opcode, i_channel, i_level, i_new_count);
        end
        o_errors  <= errors;
        o_pending <= expected_reports.size();
        o_checked <= checked;
    end

endmodule

// ===== sim/tb_debounced_pulse_counter_bank_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_debounced_pulse_counter_bank_top: stimulus and verdict for the counter bank
// Drives directed and random pin, tick and set requests under five register
// settings with random start gaps; a side checker predicts every report.
// ----------------------------------------------------------------------------
module tb_debounced_pulse_counter_bank_top;
    import dpcb_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    // three requests in flight, each at the longest save check, plus margin
    localparam int         SETTLE_CYCLES = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [2:0]  i_channel;
    logic        i_level;
    logic [31:0] i_new_count;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [2:0]  o_report_channel;
    logic [31:0] o_count_value;
    logic        o_save_request;
    logic        o_last_of_run;

    int check_errors;
    int reports_waiting;
    int reports_checked;

    // request tallies for the closing summary
    int n_pin;
    int n_tick;
    int n_set;
    int n_unused;

    // quiet: back-to-back requests with no gaps for a stretch
    bit          quiet;
    logic [15:0] save_now;

    debounced_pulse_counter_bank_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_channel        (i_channel),
        .i_level          (i_level),
        .i_new_count      (i_new_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_report_channel (o_report_channel),
        .o_count_value    (o_count_value),
        .o_save_request   (o_save_request),
        .o_last_of_run    (o_last_of_run)
    );

    dpcb_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (i_opcode),
        .i_channel        (i_channel),
        .i_level          (i_level),
        .i_new_count      (i_new_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (o_valid),
        .i_kind           (o_kind),
        .i_report_channel (o_report_channel),
        .i_count_value    (o_count_value),
        .i_save_request   (o_save_request),
        .i_last_of_run    (o_last_of_run),
        .o_errors         (check_errors),
        .o_pending        (reports_waiting),
        .o_checked        (reports_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly no gap or a short one, now and then a long hold-off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Bias loaded counts toward the wrap point and toward one below a
    // multiple of save_every, so the next edge raises a save request.
    function automatic logic [31:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 32'hffff_ffff - $urandom_range(0, 3);
        if (r < 4 && save_now != 16'd0)
            return save_now * $urandom_range(1, 5000) - 32'd1;
        return $urandom;
    endfunction

    // Present one request, hold it until accepted, then idle for a random gap.
    // Keep start high across back-to-back requests.
    task automatic send_request(input logic [1:0] op, input logic [2:0] ch,
                                input logic lvl, input logic [31:0] value);
        int gap;
        gap = pick_gap();
        start       <= 1'b1;
        i_opcode    <= op;
        i_channel   <= ch;
        i_level     <= lvl;
        i_new_count <= value;
        do @(posedge i_clk); while (busy);
        case (op)
            OP_PIN:  n_pin++;
            OP_TICK: n_tick++;
            OP_SET:  n_set++;
            default: n_unused++;
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_request(input int tick_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
            // unused fields of a tick carry random noise
            send_request(OP_TICK, 3'($urandom), 1'($urandom), $urandom);
        end else begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_request(OP_UNUSED, 3'($urandom), 1'($urandom), $urandom);
            else if (r < 6)
                send_request(OP_SET, 3'($urandom), 1'($urandom), pick_count());
            else
                send_request(OP_PIN, 3'($urandom), $urandom_range(0, 4) == 0, $urandom);
        end
    endtask

    task automatic random_burst(input int n, input int tick_pct);
        for (int i = 0; i < n; i++) begin
            if (i % 16 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send_random_request(tick_pct);
        end
        quiet = 1'b0;
    endtask

    // Advance time by n ticks, with pin and set requests sprinkled in, so the
    // report interval runs out at least once.
    task automatic run_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                send_random_request(0);
            send_request(OP_TICK, 3'($urandom), 1'($urandom), $urandom);
        end
        quiet = 1'b0;
    endtask

    // Drop start, wait for every predicted report, then let the block drain
    // requests that produce nothing.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (reports_waiting != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; upper data bits of the
    // 8-bit registers carry random filler.
    task automatic apply_setting(input logic [7:0] en, input logic [15:0] deb,
                                 input logic [7:0] iv, input logic [15:0] se);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ENABLED;
        i_cfg_data <= {8'($urandom), en};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= deb;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INTERVAL;
        i_cfg_data <= {8'($urandom), iv};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SAVE_EVERY;
        i_cfg_data <= se;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        save_now = se;
    endtask

    initial begin
        start       <= 1'b0;
        i_opcode    <= OP_PIN;
        i_channel   <= '0;
        i_level     <= 1'b1;
        i_new_count <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_ENABLED;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        n_pin    = 0;
        n_tick   = 0;
        n_set    = 0;
        n_unused = 0;
        quiet    = 1'b0;
        save_now = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: all channels, no debounce, no save requests.
        // Load the top count and take one edge so it wraps to zero.
        send_request(OP_SET, 3'd0, 1'b0, 32'hffff_ffff);
        send_request(OP_PIN, 3'd0, 1'b0, 32'd0);
        // high level and the unused opcode produce nothing
        send_request(OP_PIN, 3'd0, 1'b1, 32'd0);
        send_request(OP_UNUSED, 3'd5, 1'b0, 32'hdead_beef);
        send_request(OP_TICK, 3'd0, 1'b0, 32'd0);
        for (int c = 0; c < DPCB_CHANNELS; c++)
            send_request(OP_PIN, 3'(c), 1'b0, 32'd0);
        send_request(OP_SET, 3'd7, 1'b0, 32'h0000_0000);
        send_request(OP_SET, 3'd6, 1'b1, 32'h5555_aaaa);

        // Sparse mask, short debounce, save every third count, 1 s reports.
        apply_setting(8'ha5, 16'd3, 8'd1, 16'd3);
        // disabled channel: pin and set are both ignored
        send_request(OP_PIN, 3'd1, 1'b0, 32'd0);
        send_request(OP_SET, 3'd1, 1'b0, 32'h1234_5678);
        // too soon after the last accepted edge: rejected bounce
        send_request(OP_PIN, 3'd0, 1'b0, 32'd0);
        send_request(OP_TICK, 3'd0, 1'b0, 32'd0);
        send_request(OP_TICK, 3'd0, 1'b0, 32'd0);
        send_request(OP_PIN, 3'd0, 1'b0, 32'd0);
        send_request(OP_PIN, 3'd0, 1'b0, 32'd0);
        // count reaches a multiple of save_every
        send_request(OP_SET, 3'd2, 1'b0, 32'd2);
        send_request(OP_PIN, 3'd2, 1'b0, 32'd0);
        random_burst(60, 30);

        // Every channel, save on every count: one full eight-channel sweep.
        apply_setting(8'hff, 16'd0, 8'd1, 16'd1);
        run_ticks(1000);

        // Longest debounce, reports off, widest save divisor.
        apply_setting(8'hff, 16'hffff, 8'd0, 16'hffff);
        random_burst(30, 30);

        // Longest interval, one-ms debounce, inner channels only.
        apply_setting(8'h7e, 16'd1, 8'd255, 16'hffff);
        send_request(OP_TICK, 3'd0, 1'b0, 32'd0);
        send_request(OP_PIN, 3'd0, 1'b0, 32'd0);
        send_request(OP_SET, 3'd2, 1'b0, 32'd196604);
        send_request(OP_PIN, 3'd2, 1'b0, 32'd0);
        random_burst(60, 30);

        wait_idle();
        $display("Covered %0d requests: %0d pin, %0d tick, %0d set, %0d unused opcode,",
                 n_pin + n_tick + n_set + n_unused, n_pin, n_tick, n_set, n_unused);
        $display("under five register settings; checked %0d results, %0d mismatches.",
                 reports_checked, check_errors);
        if (check_errors == 0 && reports_waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: end the run if the block stops making progress.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run timed out after %0d cycles, %0d reports still waiting.",
                 cycles, reports_waiting);
        $display("status: fail");
        $finish;
    end

endmodule
